// ===== rtl/core/rlhsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rlhsi_pkg
// Shared types, fixed-point constants and the sine lookup table for the
// rate-limited heading and speed integrator.
// ----------------------------------------------------------------------------
package rlhsi_pkg;

    localparam int SINE_TABLE_DEPTH  = 256;
    localparam int HEADING_FRAC_BITS = 6;

    localparam int FULL_CIRCLE    = 360 << HEADING_FRAC_BITS;
    localparam int HALF_CIRCLE    = 180 << HEADING_FRAC_BITS;
    localparam int QUARTER_CIRCLE = 90 << HEADING_FRAC_BITS;
    localparam int ONE_DEGREE     = 1 << HEADING_FRAC_BITS;

    localparam int HDG_W = $clog2(FULL_CIRCLE);
    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

    // field widths of the channels
    localparam int HEADING_W = 15;
    localparam int SPEED_W   = 16;
    localparam int DT_W      = 16;
    localparam int POS_W     = 32;
    localparam int TRIG_W    = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE = CFG_IDX_W'(1);
    localparam logic [CFG_DATA_W-1:0] TURN_RATE_RST  = CFG_DATA_W'(2880);
    localparam logic [CFG_DATA_W-1:0] ACCEL_RATE_RST = CFG_DATA_W'(256);

    // exact quotients by reciprocal multiply: q = (x * RECIP) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 34;
    localparam logic [63:0] RECIP_FULL_VAL =
        ((64'd1 << RECIP_SHIFT) + 64'(FULL_CIRCLE) - 64'd1) / 64'(FULL_CIRCLE);
    localparam int RF_W = $clog2(RECIP_FULL_VAL) + 1;
    localparam logic [RF_W-1:0] RECIP_FULL = RF_W'(RECIP_FULL_VAL);

    localparam logic [63:0] RECIP_IDX_VAL =
        ((64'd1 << RECIP_SHIFT) * 64'(SINE_TABLE_DEPTH) + 64'(FULL_CIRCLE) - 64'd1)
        / 64'(FULL_CIRCLE);
    localparam int RI_W = $clog2(RECIP_IDX_VAL) + 1;
    localparam logic [RI_W-1:0] RECIP_IDX = RI_W'(RECIP_IDX_VAL);

    localparam int DHQ_W = $clog2(32768 / FULL_CIRCLE + 2);
    localparam int STQ_W = $clog2(65536 / FULL_CIRCLE + 2);

    localparam logic signed [HDG_W:0]   DIFF_ONE  = (HDG_W+1)'(ONE_DEGREE);
    localparam logic signed [HDG_W:0]   DIFF_HALF = (HDG_W+1)'(HALF_CIRCLE);
    localparam logic signed [HDG_W+1:0] HSUM_FULL = (HDG_W+2)'(FULL_CIRCLE);
    localparam logic [HDG_W:0]          HC_FULL    = (HDG_W+1)'(FULL_CIRCLE);
    localparam logic [HDG_W:0]          HC_QUARTER = (HDG_W+1)'(QUARTER_CIRCLE);

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [HEADING_W-1:0]      desired_heading;
        logic signed [SPEED_W-1:0] desired_speed;
        logic [DT_W-1:0]           tick_duration;
    } tick_t;

    typedef struct packed {
        logic [HEADING_W-1:0]      heading_out;
        logic signed [SPEED_W-1:0] speed_out;
        logic signed [SPEED_W-1:0] velocity_x;
        logic signed [SPEED_W-1:0] velocity_z;
        logic signed [POS_W-1:0]   position_x;
        logic signed [POS_W-1:0]   position_z;
    } result_t;

    typedef struct packed {
        logic load_tick;
        logic mul;
        logic mod1;
        logic mod2;
        logic upd;
        logic idx;
        logic trig;
        logic vmul;
        logic vrnd;
        logic pmul;
        logic commit;
    } cmd_t;

    typedef logic signed [TRIG_W-1:0] sine_tab_t [SINE_TABLE_DEPTH];

    // quarter-wave sine in Q1.14, Taylor series in Q30
    function automatic logic signed [TRIG_W-1:0] quarter_sine(input logic [63:0] num);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        x   = PI_HALF_Q30 * num / SINE_TABLE_DEPTH;
        x2  = (x * x) >> 30;
        sum = $signed(x);
        mag = ((x * x2) >> 30) / 64'd6;
        sum = sum - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd20;
        sum = sum + $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd42;
        sum = sum - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd72;
        sum = sum + $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd110;
        sum = sum - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd156;
        sum = sum + $signed(mag);
        r = (sum + 64'sd32768) >>> 16;
        if (r < 64'sd0)
        begin
            r = 64'sd0;
        end
        else if (r > 64'sd16384)
        begin
            r = 64'sd16384;
        end
        return TRIG_W'(r);
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t               tab;
        logic [63:0]             p;
        logic [63:0]             q;
        logic [63:0]             r;
        logic signed [TRIG_W-1:0] s;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            p = 64'(i) * 64'd4;
            q = p / SINE_TABLE_DEPTH;
            r = p % SINE_TABLE_DEPTH;
            s = quarter_sine(q[0] ? 64'(SINE_TABLE_DEPTH) - r : r);
            tab[i] = (q >= 64'd2) ? -s : s;
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ===== rtl/core/rlhsi_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlhsi_ctrl
// Sequencer: takes one tick, steps the datapath through its stages and
// holds the result valid until the receiver takes it.
// ----------------------------------------------------------------------------
module rlhsi_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tick_valid,
    output logic            tick_stall,
    output logic            result_valid,
    input  logic            result_stall,
    output rlhsi_pkg::cmd_t cmd
);
    import rlhsi_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_MUL  = 11'b000_0000_0010,
        S_MOD1 = 11'b000_0000_0100,
        S_MOD2 = 11'b000_0000_1000,
        S_UPD  = 11'b000_0001_0000,
        S_IDX  = 11'b000_0010_0000,
        S_TRIG = 11'b000_0100_0000,
        S_VMUL = 11'b000_1000_0000,
        S_VRND = 11'b001_0000_0000,
        S_PMUL = 11'b010_0000_0000,
        S_POS  = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;
    logic   accept;
    logic   out_free;

    assign accept       = tick_valid && !tick_stall;
    assign tick_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign out_free     = !result_valid_reg || !result_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (tick_valid)
                begin
                    cmd.load_tick = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_MOD1;
            end
            S_MOD1:
            begin
                cmd.mod1   = 1'b1;
                state_next = S_MOD2;
            end
            S_MOD2:
            begin
                cmd.mod2   = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_IDX;
            end
            S_IDX:
            begin
                cmd.idx    = 1'b1;
                state_next = S_TRIG;
            end
            S_TRIG:
            begin
                cmd.trig   = 1'b1;
                state_next = S_VMUL;
            end
            S_VMUL:
            begin
                cmd.vmul   = 1'b1;
                state_next = S_VRND;
            end
            S_VRND:
            begin
                cmd.vrnd   = 1'b1;
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                cmd.pmul   = 1'b1;
                state_next = S_POS;
            end
            S_POS:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.commit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    a_accept_to_pos: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##10 (state_reg == S_POS))
        else $error("tick did not reach the position stage on schedule");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result_valid_reg)
        else $error("committed result not presented");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> tick_stall)
        else $error("second transfer taken while a tick is in work");

endmodule

// ===== rtl/core/rlhsi_datapath.sv =====
// ----------------------------------------------------------------------------
// rlhsi_datapath
// Heading, speed, velocity and position arithmetic, one stage per command,
// plus the configuration registers and the output register.
// ----------------------------------------------------------------------------
module rlhsi_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rlhsi_pkg::cmd_t                     cmd,
    input  rlhsi_pkg::tick_t                    tick,
    input  logic                                cfg_we,
    input  logic [rlhsi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rlhsi_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rlhsi_pkg::result_t                  result
);
    import rlhsi_pkg::*;

    // architectural state
    logic [CFG_DATA_W-1:0]     turn_rate_reg,  turn_rate_next;
    logic [CFG_DATA_W-1:0]     accel_rate_reg, accel_rate_next;
    logic [HDG_W-1:0]          heading_reg,    heading_next;
    logic signed [SPEED_W-1:0] speed_reg,      speed_next;
    logic signed [POS_W-1:0]   pos_x_reg,      pos_x_next;
    logic signed [POS_W-1:0]   pos_z_reg,      pos_z_next;

    // working registers
    logic [HEADING_W-1:0]      dh_reg;
    logic signed [SPEED_W-1:0] ds_reg;
    logic [DT_W-1:0]           dt_reg;
    logic [15:0]               turn_raw_reg,  turn_raw_next;
    logic [15:0]               accel_step_reg, accel_step_next;
    logic [DHQ_W-1:0]          dh_q_reg,      dh_q_next;
    logic [HDG_W-1:0]          dh_mod_reg,    dh_mod_next;
    logic [STQ_W-1:0]          step_q_reg,    step_q_next;
    logic [HDG_W-1:0]          turn_step_reg, turn_step_next;
    logic signed [HDG_W:0]     diff_reg,      diff_next;
    logic [IDX_W-1:0]          idx_s_reg,     idx_s_next;
    logic [IDX_W-1:0]          idx_c_reg,     idx_c_next;
    logic signed [TRIG_W-1:0]  sin_reg;
    logic signed [TRIG_W-1:0]  cos_reg;
    logic signed [32:0]        prod_x_reg,    prod_x_next;
    logic signed [32:0]        prod_z_reg,    prod_z_next;
    logic signed [SPEED_W-1:0] vel_x_reg,     vel_x_next;
    logic signed [SPEED_W-1:0] vel_z_reg,     vel_z_next;
    logic signed [32:0]        pdt_x_reg,     pdt_x_next;
    logic signed [32:0]        pdt_z_reg,     pdt_z_next;
    result_t                   result_reg;

    // combinational temporaries
    logic [31:0]               turn_full;
    logic [31:0]               accel_full;
    logic [HEADING_W+RF_W-1:0] dh_q_prod;
    logic [15+RF_W:0]          st_q_prod;
    logic [HDG_W+RI_W-1:0]     idx_s_prod;
    logic [HDG_W+RI_W-1:0]     idx_c_prod;
    logic [31:0]               dh_mod_wide;
    logic [31:0]               step_wide;
    logic                      move;
    logic                      up;
    logic signed [HDG_W+1:0]   hsum;
    logic signed [HDG_W+1:0]   hwrap;
    logic signed [17:0]        ssum;
    logic [HDG_W:0]            hc_sum;
    logic [HDG_W-1:0]          hc;
    logic signed [33:0]        rnd_x;
    logic signed [33:0]        rnd_z;
    logic signed [33:0]        rp_x;
    logic signed [33:0]        rp_z;
    logic signed [33:0]        px;
    logic signed [33:0]        pz;

    function automatic logic signed [SPEED_W-1:0] sat16(input logic signed [33:0] v);
        logic signed [SPEED_W-1:0] r;
        if (v > 34'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -34'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[SPEED_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [33:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 34'sd2147483647)
        begin
            r = 32'sh7fff_ffff;
        end
        else if (v < -34'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    // configuration
    always_comb
    begin
        turn_rate_next  = turn_rate_reg;
        accel_rate_next = accel_rate_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_TURN_RATE:  turn_rate_next  = cfg_data;
                REG_ACCEL_RATE: accel_rate_next = cfg_data;
                default:        ;
            endcase
        end
    end

    // rate products, quotients, remainders and heading difference
    always_comb
    begin
        turn_full       = turn_rate_reg * dt_reg;
        accel_full      = accel_rate_reg * dt_reg;
        turn_raw_next   = turn_full[31:16];
        accel_step_next = accel_full[31:16];
        dh_q_prod       = dh_reg * RECIP_FULL;
        dh_q_next       = dh_q_prod[RECIP_SHIFT +: DHQ_W];

        st_q_prod   = turn_raw_reg * RECIP_FULL;
        step_q_next = st_q_prod[RECIP_SHIFT +: STQ_W];
        dh_mod_wide = 32'(dh_reg) - 32'(dh_q_reg) * 32'(FULL_CIRCLE);
        dh_mod_next = dh_mod_wide[HDG_W-1:0];

        step_wide      = 32'(turn_raw_reg) - 32'(step_q_reg) * 32'(FULL_CIRCLE);
        turn_step_next = step_wide[HDG_W-1:0];
        diff_next      = $signed({1'b0, dh_mod_reg}) - $signed({1'b0, heading_reg});
    end

    // heading and speed update
    always_comb
    begin
        move = (diff_reg >= DIFF_ONE) || (diff_reg <= -DIFF_ONE);
        if (diff_reg > 0)
        begin
            up = !(diff_reg > DIFF_HALF);
        end
        else
        begin
            up = (diff_reg < -DIFF_HALF);
        end
        if (up)
        begin
            hsum = $signed({2'b00, heading_reg}) + $signed({2'b00, turn_step_reg});
        end
        else
        begin
            hsum = $signed({2'b00, heading_reg}) - $signed({2'b00, turn_step_reg});
        end
        if (hsum < 0)
        begin
            hwrap = hsum + HSUM_FULL;
        end
        else if (hsum >= HSUM_FULL)
        begin
            hwrap = hsum - HSUM_FULL;
        end
        else
        begin
            hwrap = hsum;
        end
        heading_next = heading_reg;
        if (cmd.upd && move)
        begin
            heading_next = hwrap[HDG_W-1:0];
        end

        if (speed_reg < ds_reg)
        begin
            ssum = 18'(speed_reg) + $signed({2'b00, accel_step_reg});
        end
        else if (speed_reg > ds_reg)
        begin
            ssum = 18'(speed_reg) - $signed({2'b00, accel_step_reg});
        end
        else
        begin
            ssum = 18'(speed_reg);
        end
        speed_next = speed_reg;
        if (cmd.upd)
        begin
            speed_next = sat16(34'(ssum));
        end
    end

    // table indexes, velocity and position
    always_comb
    begin
        hc_sum = {1'b0, heading_reg} + HC_QUARTER;
        if (hc_sum >= HC_FULL)
        begin
            hc_sum = hc_sum - HC_FULL;
        end
        hc         = hc_sum[HDG_W-1:0];
        idx_s_prod = heading_reg * RECIP_IDX;
        idx_c_prod = hc * RECIP_IDX;
        idx_s_next = idx_s_prod[RECIP_SHIFT +: IDX_W];
        idx_c_next = idx_c_prod[RECIP_SHIFT +: IDX_W];

        prod_x_next = 33'(speed_reg * cos_reg);
        prod_z_next = -33'(speed_reg * sin_reg);

        rnd_x      = (34'(prod_x_reg) + 34'sd8192) >>> 14;
        rnd_z      = (34'(prod_z_reg) + 34'sd8192) >>> 14;
        vel_x_next = sat16(rnd_x);
        vel_z_next = sat16(rnd_z);

        pdt_x_next = 33'(vel_x_reg * $signed({1'b0, dt_reg}));
        pdt_z_next = 33'(vel_z_reg * $signed({1'b0, dt_reg}));

        rp_x = (34'(pdt_x_reg) + 34'sd32768) >>> 16;
        rp_z = (34'(pdt_z_reg) + 34'sd32768) >>> 16;
        px   = 34'(pos_x_reg) + rp_x;
        pz   = 34'(pos_z_reg) + rp_z;
        pos_x_next = pos_x_reg;
        pos_z_next = pos_z_reg;
        if (cmd.commit)
        begin
            pos_x_next = sat32(px);
            pos_z_next = sat32(pz);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_rate_reg  <= TURN_RATE_RST;
            accel_rate_reg <= ACCEL_RATE_RST;
            heading_reg    <= '0;
            speed_reg      <= '0;
            pos_x_reg      <= '0;
            pos_z_reg      <= '0;
        end
        else
        begin
            turn_rate_reg  <= turn_rate_next;
            accel_rate_reg <= accel_rate_next;
            heading_reg    <= heading_next;
            speed_reg      <= speed_next;
            pos_x_reg      <= pos_x_next;
            pos_z_reg      <= pos_z_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_tick)
        begin
            dh_reg <= tick.desired_heading;
            ds_reg <= tick.desired_speed;
            dt_reg <= tick.tick_duration;
        end
        if (cmd.mul)
        begin
            turn_raw_reg   <= turn_raw_next;
            accel_step_reg <= accel_step_next;
            dh_q_reg       <= dh_q_next;
        end
        if (cmd.mod1)
        begin
            step_q_reg <= step_q_next;
            dh_mod_reg <= dh_mod_next;
        end
        if (cmd.mod2)
        begin
            turn_step_reg <= turn_step_next;
            diff_reg      <= diff_next;
        end
        if (cmd.idx)
        begin
            idx_s_reg <= idx_s_next;
            idx_c_reg <= idx_c_next;
        end
        if (cmd.trig)
        begin
            sin_reg <= SINE_TAB[idx_s_reg];
            cos_reg <= SINE_TAB[idx_c_reg];
        end
        if (cmd.vmul)
        begin
            prod_x_reg <= prod_x_next;
            prod_z_reg <= prod_z_next;
        end
        if (cmd.vrnd)
        begin
            vel_x_reg <= vel_x_next;
            vel_z_reg <= vel_z_next;
        end
        if (cmd.pmul)
        begin
            pdt_x_reg <= pdt_x_next;
            pdt_z_reg <= pdt_z_next;
        end
        if (cmd.commit)
        begin
            result_reg.heading_out <= HEADING_W'(heading_reg);
            result_reg.speed_out   <= speed_reg;
            result_reg.velocity_x  <= vel_x_reg;
            result_reg.velocity_z  <= vel_z_reg;
            result_reg.position_x  <= pos_x_next;
            result_reg.position_z  <= pos_z_next;
        end
    end

    assign result = result_reg;

    a_heading_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd && (diff_reg < DIFF_ONE) && (diff_reg > -DIFF_ONE) |=> $stable(heading_reg))
        else $error("heading moved inside the one-degree band");

    a_speed_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd && (speed_reg == ds_reg) |=> $stable(speed_reg))
        else $error("speed moved although already at target");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.idx |=> (32'(idx_s_reg) < 32'(SINE_TABLE_DEPTH))
                 && (32'(idx_c_reg) < 32'(SINE_TABLE_DEPTH)))
        else $error("sine table index out of range");

endmodule

// ===== rtl/core/rate_limited_heading_speed_integrator_core.sv =====
// ----------------------------------------------------------------------------
// rate_limited_heading_speed_integrator_core
// Heading and speed integrator with turn and acceleration limits.
//
// Input channel tick (valid/stall): desired heading, desired speed and tick
// length. One transfer is taken only while the block is idle; tick_stall is
// high while a tick is being worked on.
// Output channel result (valid/stall): heading, speed, velocity and position
// after the tick. The result sits in an output register, so a new tick is
// taken while an earlier result still waits.
// The sequencer walks the tick through ten datapath steps (rate products,
// modulo reduction, update, table index, table read, velocity multiply,
// rounding, position multiply, accumulate) and raises result_valid after
// the last one; a new tick is taken only once the previous one is through.
// If the receiver still holds the previous result, the last step waits until
// the output register frees up.
// Config: cfg_we writes turn_rate (index 0) or accel_rate (index 1); write
// only while idle. Reset clears heading, speed and position and loads the
// default rates; the sine table is constant, so no start-up pass is needed.
// ----------------------------------------------------------------------------
module rate_limited_heading_speed_integrator_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick_valid,
    output logic                             tick_stall,
    input  rlhsi_pkg::tick_t                 tick,
    output logic                             result_valid,
    input  logic                             result_stall,
    output rlhsi_pkg::result_t               result,
    input  logic                             cfg_we,
    input  logic [rlhsi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rlhsi_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rlhsi_pkg::*;

    cmd_t cmd;

    rlhsi_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    rlhsi_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .tick      (tick),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule
